FILE: design/hash_keyed_sorted_record_table_defines.svh
// Assertion macros shared by the table design
`ifndef HASH_KEYED_SORTED_RECORD_TABLE_DEFINES_SVH
`define HASH_KEYED_SORTED_RECORD_TABLE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define HKT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define HKT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/hkt_pkg.sv
// ----------------------------------------------------------------------------
// hkt_pkg
// Types, codes and hash helpers for the sorted record table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package hkt_pkg;
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    localparam logic [1:0] OUT_INSERTED = 2'd0;
    localparam logic [1:0] OUT_HIT      = 2'd1;
    localparam logic [1:0] OUT_MISS     = 2'd2;
    localparam logic [1:0] OUT_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         name_byte;
        logic               last_byte;
        logic signed [31:0] record_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] key_hash;
        logic [1:0]  outcome;
    } out_item_t;

    // One finished key handed from the hasher to the table engine
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key_hash;
        logic [31:0] record_value;
    } op_t;

    function automatic logic [31:0] hash_round(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        t = h + {24'd0, b};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [31:0] hash_finish(input logic [31:0] h);
        logic [31:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction
endpackage
`default_nettype wire

FILE: design/hkt_ram.sv
// ----------------------------------------------------------------------------
// hkt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hkt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: design/hkt_front.sv
// ----------------------------------------------------------------------------
// hkt_front
// Byte hasher: folds name bytes and emits one finished key per name.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hkt_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire hkt_pkg::in_item_t s_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output hkt_pkg::op_t          op_data,
    output logic                  op_valid,
    input  wire logic             op_ready
);
    import hkt_pkg::*;

    logic [31:0] hash_reg, hash_next;
    logic [31:0] rounded;
    logic        take;

    assign s_ready  = !op_valid || op_ready;
    assign take     = s_valid && s_ready;
    assign rounded  = hash_round(hash_reg, s_data.name_byte);

    always_comb begin
        hash_next = hash_reg;
        if (take) begin
            hash_next = s_data.last_byte ? 32'd0 : rounded;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= 32'd0;
            op_valid <= 1'b0;
        end else begin
            hash_reg <= hash_next;
            if (take) begin
                op_valid <= s_data.last_byte;
            end else if (op_ready) begin
                op_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && s_data.last_byte) begin
            op_data.command      <= s_data.command;
            op_data.key_hash     <= hash_finish(rounded);
            op_data.record_value <= s_data.record_value;
        end
    end
endmodule
`default_nettype wire

FILE: design/hkt_queue.sv
// ----------------------------------------------------------------------------
// hkt_queue
// Two-entry queue of finished keys between hasher and table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hkt_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire hkt_pkg::op_t  in_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    output hkt_pkg::op_t       out_data,
    output logic               out_valid,
    input  wire logic          out_ready
);
    import hkt_pkg::*;

    op_t         slot_reg [2];
    logic        rd_reg, wr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = slot_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= in_data;
        end
    end
endmodule
`default_nettype wire

FILE: design/hkt_back.sv
// ----------------------------------------------------------------------------
// hkt_back
// Table engine: scans the sorted store and inserts, deletes or looks up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hash_keyed_sorted_record_table_defines.svh"
module hkt_back #(
    parameter int TABLE_ENTRIES = hkt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire hkt_pkg::op_t   op_data,
    input  wire logic           op_valid,
    output logic                op_ready,
    output hkt_pkg::out_item_t  m_data,
    output logic                m_valid,
    input  wire logic           m_ready
);
    import hkt_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_SHUP  = 6'b001000,
        ST_SHDN  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    op_t         op_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;     // scan / shift position
    logic [CW-1:0] pos_reg, pos_next;     // lower bound
    logic [1:0]    res_out_reg, res_out_next;
    logic [31:0]   res_hash_reg, res_hash_next;
    logic          mv_reg, mv_next;

    // Memory ports: one read and one write per cycle on each store
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wh, wv, rh, rv;

    hkt_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_hash_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wh), .raddr(raddr), .rdata(rh)
    );
    hkt_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_val_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wv), .raddr(raddr), .rdata(rv)
    );

    // Read issued last cycle at idx_reg-1 in scan; hold rdata sense
    logic rd_pending_reg, rd_pending_next;

    assign op_ready = state_reg == ST_IDLE && !mv_reg;
    assign m_valid  = mv_reg;
    assign m_data   = '{key_hash: res_hash_reg, outcome: res_out_reg};

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        res_out_next    = res_out_reg;
        res_hash_next   = res_hash_reg;
        mv_next         = mv_reg && !m_ready;
        rd_pending_next = 1'b0;
        we    = 1'b0;
        waddr = '0;
        raddr = '0;
        wh    = op_reg.key_hash;
        wv    = op_reg.record_value;
        case (state_reg)
            ST_IDLE: begin
                if (op_valid && op_ready) begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Compare data read for idx_reg-1, issue read at idx_reg
                if (rd_pending_reg && !(rh < op_reg.key_hash)) begin
                    // Read the entry at pos again so the check sees it
                    raddr      = AW'(idx_reg - CW'(1));
                    pos_next   = idx_reg - CW'(1);
                    state_next = ST_CHECK;
                end else if (idx_reg == count_reg) begin
                    pos_next   = count_reg;
                    state_next = ST_CHECK;
                end else begin
                    raddr           = idx_reg[AW-1:0];
                    idx_next        = idx_reg + CW'(1);
                    rd_pending_next = 1'b1;
                end
            end
            ST_CHECK: begin
                // rh holds the entry at pos when pos < count
                if (pos_reg < count_reg && rh == op_reg.key_hash) begin
                    res_hash_next = op_reg.key_hash;
                    res_out_next  = OUT_HIT;
                    if (op_reg.command == CMD_INSERT) begin
                        we         = 1'b1;
                        waddr      = pos_reg[AW-1:0];
                        wh         = rh;
                        state_next = ST_DONE;
                    end else if (op_reg.command == CMD_DELETE) begin
                        idx_next   = pos_reg;
                        state_next = ST_SHDN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    res_hash_next = op_reg.key_hash;
                    if (op_reg.command == CMD_INSERT) begin
                        if (count_reg == FULL_COUNT) begin
                            res_out_next = OUT_FULL;
                            state_next   = ST_DONE;
                        end else begin
                            res_out_next = OUT_INSERTED;
                            idx_next     = count_reg;
                            state_next   = ST_SHUP;
                        end
                    end else if (op_reg.command == CMD_DELETE) begin
                        res_out_next = OUT_MISS;
                        state_next   = ST_DONE;
                    end else begin
                        res_hash_next = '1;
                        res_out_next  = OUT_MISS;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_SHUP: begin
                // Read idx-1, write it to idx next cycle
                if (rd_pending_reg) begin
                    we    = 1'b1;
                    waddr = idx_reg[AW-1:0];
                    wh    = rh;
                    wv    = rv;
                end
                if (idx_reg == pos_reg && !rd_pending_reg) begin
                    we         = 1'b1;
                    waddr      = pos_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                    state_next = ST_DONE;
                end else if (rd_pending_reg) begin
                    idx_next = idx_reg - CW'(1);
                end else begin
                    raddr           = AW'(idx_reg - CW'(1));
                    rd_pending_next = 1'b1;
                end
            end
            ST_SHDN: begin
                // Read idx+1, write it to idx
                if (rd_pending_reg) begin
                    we       = 1'b1;
                    waddr    = idx_reg[AW-1:0];
                    wh       = rh;
                    wv       = rv;
                    idx_next = idx_reg + CW'(1);
                end else if (idx_reg + CW'(1) >= count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_DONE;
                end else begin
                    raddr           = AW'(idx_reg + CW'(1));
                    rd_pending_next = 1'b1;
                end
            end
            ST_DONE: begin
                mv_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            mv_reg         <= 1'b0;
            rd_pending_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            mv_reg         <= mv_next;
            rd_pending_reg <= rd_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        res_out_reg  <= res_out_next;
        res_hash_reg <= res_hash_next;
        if (op_valid && op_ready) begin
            op_reg <= op_data;
        end
    end

    `HKT_ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1, count_reg <= FULL_COUNT)
    `HKT_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !op_ready)
    `HKT_ASSERT_NEXT(a_done_shows, aclk, aresetn, state_reg == ST_DONE, m_valid)
    `HKT_ASSERT_NEXT(a_full_holds, aclk, aresetn,
        state_reg == ST_DONE && res_out_reg == OUT_FULL, $stable(count_reg))
endmodule
`default_nettype wire

FILE: design/hash_keyed_sorted_record_table.sv
// ----------------------------------------------------------------------------
// hash_keyed_sorted_record_table
// Sorted record table keyed by the one-at-a-time hash of a streamed name.
// ----------------------------------------------------------------------------
//  channel | direction | payload       | handshake
//  s_      | in        | in_item_t     | s_valid / s_ready
//  m_      | out       | out_item_t    | m_valid / m_ready
//
//  Name bytes are taken one per cycle while the key queue has room.
//  A table operation scans the store to classify the key, then shifts
//  entries on insert or delete; each step goes through the single read
//  port of the entry RAMs, and no new key is taken until it is done.
//  Reset (aresetn low, synchronous) empties the table; no clearing pass.
//  Stalls on m_ready hold the result and stop the engine; the hasher
//  keeps going until the key queue fills.
`timescale 1ns / 1ps
`default_nettype none
module hash_keyed_sorted_record_table #(
    parameter int TABLE_ENTRIES = hkt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire hkt_pkg::in_item_t  s_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output hkt_pkg::out_item_t      m_data,
    output logic                    m_valid,
    input  wire logic               m_ready
);
    import hkt_pkg::*;

    op_t  f_data, q_data;
    logic f_valid, f_ready, q_valid, q_ready;

    // Front: hash bytes, hand over one key per name
    hkt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_data(s_data), .s_valid(s_valid), .s_ready(s_ready),
        .op_data(f_data), .op_valid(f_valid), .op_ready(f_ready)
    );

    // Decouple hasher from the table engine
    hkt_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_data(f_data), .in_valid(f_valid), .in_ready(f_ready),
        .out_data(q_data), .out_valid(q_valid), .out_ready(q_ready)
    );

    // Back: scan and edit the sorted store
    hkt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .op_data(q_data), .op_valid(q_valid), .op_ready(q_ready),
        .m_data(m_data), .m_valid(m_valid), .m_ready(m_ready)
    );
endmodule
`default_nettype wire
